// ===== rtl/fdmd_pkg.sv =====
// fdmd_pkg: shared types and constants for the frame difference motion detector
// no dependencies; imported by every module of the block

package fdmd_pkg;

	localparam int MAG_W   = 16;
	localparam int THR_W   = 16;
	localparam int BIN_W   = 8;
	localparam int CNT_W   = 9;
	localparam int SUM_W   = 24;
	localparam int LVL_W   = 8;
	localparam int CIDX_W  = 8;
	localparam int CDATA_W = 16;

	localparam logic [CIDX_W-1:0] CFG_ENABLE    = 8'd0;
	localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 8'd1;
	localparam logic [CIDX_W-1:0] CFG_FIRST_BIN = 8'd2;
	localparam logic [CIDX_W-1:0] CFG_LAST_BIN  = 8'd3;

	localparam logic [LVL_W-1:0] LEVEL_MAX = 8'd255;

	typedef struct packed {
		logic             enable;
		logic [THR_W-1:0] threshold;
		logic [BIN_W-1:0] first_bin;
		logic [BIN_W-1:0] last_bin;
	} cfg_t;

	typedef struct packed {
		logic             compared;
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
		logic [MAG_W-1:0] best;
		logic [BIN_W-1:0] bin;
		logic [THR_W-1:0] threshold;
	} frame_sum_t;

endpackage

// ===== rtl/fdmd_front.sv =====
// fdmd_front: takes bins, keeps the previous frame's magnitudes and accumulates changes
// depends on fdmd_pkg; feeds one frame summary per frame end into fdmd_queue

module fdmd_front #(
	parameter int MAX_BINS = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [15:0]               magnitude,
	input  logic                      frame_end,
	input  fdmd_pkg::cfg_t            cfg,
	input  logic                      q_full,
	output logic                      full,
	output logic                      q_push,
	output fdmd_pkg::frame_sum_t      q_data
);
	import fdmd_pkg::*;

	localparam int PW        = $clog2(MAX_BINS + 1);
	localparam int MEM_DEPTH = (MAX_BINS < 256) ? MAX_BINS : 256;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam int CW        = (PW > BIN_W) ? PW : BIN_W;

	logic [MAG_W-1:0] mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] valid_q;

	logic [PW-1:0]    pos_q;
	logic             awaiting_q;
	logic             accept, in_win, step;
	logic [AW-1:0]    idx;

	logic             s1_valid_q, s1_last_q, s1_exam_q, s1_cmp_q, s1_pv_q;
	logic [MAG_W-1:0] s1_mag_q, s1_rd_q;
	logic [BIN_W-1:0] s1_bin_q;

	logic [CNT_W-1:0] acc_count_q, nxt_count;
	logic [SUM_W-1:0] acc_sum_q, nxt_sum;
	logic [MAG_W-1:0] acc_best_q, nxt_best;
	logic [BIN_W-1:0] acc_bin_q, nxt_bin;
	logic [MAG_W-1:0] prev, diff;
	logic             hit;

	assign full   = s1_valid_q && s1_last_q && q_full;
	assign accept = push && !full;
	assign step   = s1_valid_q && !full;
	assign idx    = pos_q[AW-1:0];
	assign in_win = cfg.enable && (pos_q < PW'(MAX_BINS))
		&& (CW'(pos_q) >= CW'(cfg.first_bin)) && (CW'(pos_q) <= CW'(cfg.last_bin));

	// previous frame store, read before write
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_rd_q <= mem[idx];
			if (in_win) begin
				mem[idx] <= magnitude;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			pos_q      <= '0;
			awaiting_q <= 1'b1;
		end else if (accept) begin
			if (in_win) begin
				valid_q[idx] <= 1'b1;
			end
			if (frame_end) begin
				pos_q <= '0;
			end else if (pos_q < PW'(MAX_BINS)) begin
				pos_q <= pos_q + 1'b1;
			end
			if (frame_end && cfg.enable) begin
				awaiting_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!full) begin
			s1_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_last_q <= frame_end;
			s1_exam_q <= in_win && !awaiting_q;
			s1_cmp_q  <= cfg.enable && !awaiting_q;
			s1_pv_q   <= valid_q[idx];
			s1_mag_q  <= magnitude;
			s1_bin_q  <= BIN_W'(pos_q);
		end
	end

	// change against the stored magnitude
	always_comb begin
		prev      = s1_pv_q ? s1_rd_q : '0;
		diff      = (s1_mag_q >= prev) ? (s1_mag_q - prev) : (prev - s1_mag_q);
		hit       = s1_exam_q && (diff > cfg.threshold);
		nxt_count = acc_count_q;
		nxt_sum   = acc_sum_q;
		nxt_best  = acc_best_q;
		nxt_bin   = acc_bin_q;
		if (hit) begin
			nxt_count = acc_count_q + 1'b1;
			nxt_sum   = acc_sum_q + SUM_W'(diff);
			if (diff > acc_best_q) begin
				nxt_best = diff;
				nxt_bin  = s1_bin_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_count_q <= '0;
			acc_sum_q   <= '0;
			acc_best_q  <= '0;
			acc_bin_q   <= '0;
		end else if (step) begin
			if (s1_last_q) begin
				acc_count_q <= '0;
				acc_sum_q   <= '0;
				acc_best_q  <= '0;
				acc_bin_q   <= '0;
			end else begin
				acc_count_q <= nxt_count;
				acc_sum_q   <= nxt_sum;
				acc_best_q  <= nxt_best;
				acc_bin_q   <= nxt_bin;
			end
		end
	end

	assign q_push             = step && s1_last_q;
	assign q_data.compared    = s1_cmp_q;
	assign q_data.count       = nxt_count;
	assign q_data.sum         = nxt_sum;
	assign q_data.best        = nxt_best;
	assign q_data.bin         = nxt_bin;
	assign q_data.threshold   = cfg.threshold;

endmodule

// ===== rtl/fdmd_queue.sv =====
// fdmd_queue: two-entry queue of frame summaries between front and back
// depends on fdmd_pkg

module fdmd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  fdmd_pkg::frame_sum_t wr_data,
	input  logic                 rd,
	output logic                 q_full,
	output logic                 q_valid,
	output fdmd_pkg::frame_sum_t rd_data
);
	import fdmd_pkg::*;

	localparam int DEPTH = 2;

	frame_sum_t  ent_q [DEPTH];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;

	assign q_full  = (cnt_q == 2'(DEPTH));
	assign q_valid = (cnt_q != 2'd0);
	assign rd_data = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !q_full) begin
			ent_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr && !q_full) begin
				wp_q <= ~wp_q;
			end
			if (rd && q_valid) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(wr && !q_full) - 2'(rd && q_valid);
		end
	end

endmodule

// ===== rtl/fdmd_back.sv =====
// fdmd_back: turns a frame summary into a result, serial divides for the motion level
// depends on fdmd_pkg; reads fdmd_queue and holds the result register

module fdmd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  fdmd_pkg::frame_sum_t q_head,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output logic                 frame_compared,
	output logic                 motion_detected,
	output logic [8:0]           motion_bin_count,
	output logic [7:0]           peak_bin,
	output logic [15:0]          peak_delta,
	output logic [7:0]           motion_level
);
	import fdmd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIVA = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_DIVB = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	localparam int RW = THR_W + 2;

	logic [2:0]       st_q;
	logic [4:0]       cnt_q;
	logic [RW-1:0]    rem_q, dsr, dsr_b;
	logic [15:0]      quo_q;
	logic [SUM_W-1:0] prod_q;
	logic [LVL_W-1:0] lvl_q;
	frame_sum_t       ent_q;
	logic [RW:0]      trial;
	logic             ge;
	logic             out_valid_q, out_free;

	assign dsr_b    = {ent_q.threshold, 2'b00};
	assign dsr      = (st_q == ST_DIVA) ? RW'(ent_q.count) : dsr_b;
	assign trial    = {rem_q, quo_q[15]};
	assign ge       = trial >= (RW + 1)'(dsr);
	assign out_free = !out_valid_q || pop;
	assign q_pop    = (st_q == ST_IDLE) && q_valid;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_head.compared && (q_head.count != '0)) begin
							st_q <= ST_DIVA;
						end else begin
							st_q <= ST_DONE;
						end
					end
				end
				ST_DIVA: if (cnt_q == 5'd1) st_q <= ST_MUL;
				ST_MUL:  st_q <= ST_CHK;
				ST_CHK: begin
					if ((ent_q.threshold == '0) || ({2'b00, prod_q} >= {dsr_b, 8'h00})) begin
						st_q <= ST_DONE;
					end else begin
						st_q <= ST_DIVB;
					end
				end
				ST_DIVB: if (cnt_q == 5'd1) st_q <= ST_DONE;
				ST_DONE: if (out_free) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: average then scaled level, one quotient bit a cycle
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				ent_q <= q_head;
				lvl_q <= '0;
				rem_q <= RW'(q_head.sum[SUM_W-1:16]);
				quo_q <= q_head.sum[15:0];
				cnt_q <= 5'd16;
			end
			ST_DIVA, ST_DIVB: begin
				rem_q <= ge ? RW'(trial - (RW + 1)'(dsr)) : RW'(trial);
				quo_q <= {quo_q[14:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (st_q == ST_DIVB && cnt_q == 5'd1) begin
					lvl_q <= {quo_q[6:0], ge};
				end
			end
			ST_MUL: begin
				prod_q <= {quo_q, 8'h00} - SUM_W'(quo_q);
			end
			ST_CHK: begin
				lvl_q <= LEVEL_MAX;
				rem_q <= RW'(prod_q[SUM_W-1:8]);
				quo_q <= {prod_q[7:0], 8'h00};
				cnt_q <= 5'd8;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_DONE && out_free) begin
			frame_compared   <= ent_q.compared;
			if (ent_q.compared && ent_q.count != '0) begin
				motion_detected  <= 1'b1;
				motion_bin_count <= ent_q.count;
				peak_bin         <= ent_q.bin;
				peak_delta       <= ent_q.best;
				motion_level     <= lvl_q;
			end else begin
				motion_detected  <= 1'b0;
				motion_bin_count <= '0;
				peak_bin         <= '0;
				peak_delta       <= '0;
				motion_level     <= '0;
			end
		end
	end

endmodule

// ===== rtl/frame_difference_motion_detector.sv =====
// frame_difference_motion_detector: top level with configuration registers
// depends on fdmd_pkg, fdmd_front, fdmd_queue and fdmd_back

// Range-bin magnitudes are pushed one per cycle while full is low, frame_end on the last bin
// of a frame; each frame end yields one result, popped from the result side. The front part
// takes one bin every cycle through a read-before-write store of the previous frame and a
// one-stage accumulator, so it stalls only when the two-entry summary queue is full. For each
// frame the back part pops a summary and, as needed, runs a 16-step divide for the average,
// a multiply, a saturation check and an 8-step divide for the level, then loads the result
// register, while the front goes on taking bins. Bins at or past MAX_BINS are never examined.
// Configuration is to be written only while idle; the block does not enforce it.

module frame_difference_motion_detector #(
	parameter int MAX_BINS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] magnitude,
	input  logic        frame_end,
	output logic        empty,
	input  logic        pop,
	output logic        frame_compared,
	output logic        motion_detected,
	output logic [8:0]  motion_bin_count,
	output logic [7:0]  peak_bin,
	output logic [15:0] peak_delta,
	output logic [7:0]  motion_level,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import fdmd_pkg::*;

	cfg_t       cfg_q;
	logic       q_push, q_full, q_valid, q_pop;
	frame_sum_t q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable    <= 1'b1;
			cfg_q.threshold <= 16'd100;
			cfg_q.first_bin <= 8'd0;
			cfg_q.last_bin  <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ENABLE:    cfg_q.enable    <= cfg_data[0];
				CFG_THRESHOLD: cfg_q.threshold <= cfg_data;
				CFG_FIRST_BIN: cfg_q.first_bin <= cfg_data[BIN_W-1:0];
				CFG_LAST_BIN:  cfg_q.last_bin  <= cfg_data[BIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fdmd_front #(
		.MAX_BINS(MAX_BINS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.magnitude (magnitude),
		.frame_end (frame_end),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.full      (full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	fdmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_data (q_wdata),
		.rd      (q_pop),
		.q_full  (q_full),
		.q_valid (q_valid),
		.rd_data (q_rdata)
	);

	fdmd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_head           (q_rdata),
		.q_pop            (q_pop),
		.pop              (pop),
		.empty            (empty),
		.frame_compared   (frame_compared),
		.motion_detected  (motion_detected),
		.motion_bin_count (motion_bin_count),
		.peak_bin         (peak_bin),
		.peak_delta       (peak_delta),
		.motion_level     (motion_level)
	);

endmodule
